### rtl/irbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irbd_pkg
// Shared types and constants for the pulsed IR beam door detector.
// ----------------------------------------------------------------------------
package irbd_pkg;

    localparam int CHANNELS      = 8;
    localparam int COUNT_WIDTH   = 10;
    localparam int CH_W          = 3;
    localparam int ADDR_W        = $clog2(CHANNELS);
    localparam int ACT_W         = 4;
    localparam int CFG_W         = 10;
    localparam int SETTLE_TICKS  = 5;
    localparam int QUALIFY_COUNT = 2;

    // configuration register indexes
    localparam logic REG_DELAY  = 1'b0;
    localparam logic REG_ACTIVE = 1'b1;

    localparam logic [CFG_W-1:0] DELAY_RESET  = CFG_W'(20);
    localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(1);

    typedef struct packed {
        logic                   tx_on;
        logic [COUNT_WIDTH-1:0] off_count;
        logic [COUNT_WIDTH-1:0] on_count;
        logic [COUNT_WIDTH-1:0] intf_count;
        logic [1:0]             confirm_count;
        logic [1:0]             miss_count;
        logic                   beam_status;
    } t_rec;

endpackage

### rtl/ir_beam_door_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_beam_door_detector
// Per-channel pulsed IR door sensor; channel records kept in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_stall) carries one tick for one sensor
//    channel: channel index and receiver pin level (0 = beam seen).
//  - Output channel (o_out_valid / i_out_stall) returns one result per tick:
//    echoed channel, transmitter drive after the tick and detected status.
//  - Config: i_cfg_we with i_cfg_index / i_cfg_data, written while idle.
//    Index 0 is the on/off period, index 1 the number of active channels.
//  - A tick passes the update stage and the result register to the output port.
//    One tick per cycle is sustained unless the output stalls; the record
//    RAM is read on accept and written back from the update stage, with the
//    write-back record forwarded when consecutive ticks hit the same channel.
//  - Reset clears all channel records (per-entry valid bits, no sweep),
//    sets the period to 20 and the active channel count to 1.
//  - When the receiver stalls, the result register holds; a stalled result
//    with a pending tick in the update stage stalls the input side.
// ----------------------------------------------------------------------------
module ir_beam_door_detector
    import irbd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [CH_W-1:0]  i_channel,
    input  logic             i_rx_level,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [CH_W-1:0]  o_out_channel,
    output logic             o_tx_level,
    output logic             o_detected,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_rec                  r_mem [CHANNELS];
    logic [CHANNELS-1:0]   r_vld;
    t_rec                  r_rd_rec;
    logic                  r_rd_ok;

    logic [CFG_W-1:0]      r_delay;
    logic [ACT_W-1:0]      r_active;

    logic                  r_s1_valid;
    logic [CH_W-1:0]       r_s1_ch;
    logic                  r_s1_beam;
    logic                  r_fwd;
    t_rec                  r_wr_rec;

    logic                  r_out_valid;
    logic [CH_W-1:0]       r_out_ch;
    logic                  r_out_tx;
    logic                  r_out_det;

    logic                  in_acc;
    logic                  s1_fire;
    logic                  s1_wen;
    logic                  s1_in_range;
    logic                  s1_active;
    logic [ACT_W-1:0]      act_lim;
    logic [COUNT_WIDTH-1:0] period;
    t_rec                  cur;
    t_rec                  n_rec;

    assign s1_fire = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign in_acc  = i_in_valid && !o_in_stall;
    assign o_in_stall = r_s1_valid && !s1_fire;

    assign act_lim = (r_active > ACT_W'(CHANNELS)) ? ACT_W'(CHANNELS) : r_active;
    assign period  = (r_delay > CFG_W'((1 << COUNT_WIDTH) - 1))
                   ? COUNT_WIDTH'((1 << COUNT_WIDTH) - 1) : COUNT_WIDTH'(r_delay);

    assign s1_in_range = ({1'b0, r_s1_ch} < (CH_W+1)'(CHANNELS));
    assign s1_active   = s1_in_range && (ACT_W'(r_s1_ch) < act_lim);
    assign s1_wen      = s1_fire && s1_active;

    // freshest copy of the record: last write-back, RAM data, or reset value
    always_comb begin
        if (r_fwd) begin
            cur = r_wr_rec;
        end else if (r_rd_ok) begin
            cur = r_rd_rec;
        end else begin
            cur = '0;
        end
    end

    always_comb begin
        n_rec = cur;
        if (!cur.tx_on) begin
            n_rec.on_count = '0;
            if (cur.off_count < period) begin
                n_rec.off_count = cur.off_count + 1'b1;
                if (r_s1_beam) begin
                    // limit is period - SETTLE_TICKS; for short periods the count never rises
                    if (({1'b0, cur.intf_count} + (COUNT_WIDTH+1)'(SETTLE_TICKS))
                            < {1'b0, period}) begin
                        n_rec.intf_count = cur.intf_count + 1'b1;
                    end else begin
                        n_rec.confirm_count = '0;
                    end
                end
            end else begin
                n_rec.tx_on = 1'b1;
            end
        end else begin
            n_rec.off_count = '0;
            if (cur.on_count < period) begin
                n_rec.on_count = cur.on_count + 1'b1;
            end else begin
                if (r_s1_beam && (cur.intf_count == '0)) begin
                    if (cur.on_count > COUNT_WIDTH'(SETTLE_TICKS)) begin
                        if (cur.confirm_count < 2'(QUALIFY_COUNT)) begin
                            n_rec.confirm_count = cur.confirm_count + 1'b1;
                        end else begin
                            n_rec.beam_status = 1'b1;
                        end
                    end
                    n_rec.miss_count = '0;
                end else begin
                    n_rec.confirm_count = '0;
                    if (cur.on_count > COUNT_WIDTH'(SETTLE_TICKS)) begin
                        if (cur.miss_count < 2'(QUALIFY_COUNT)) begin
                            n_rec.miss_count = cur.miss_count + 1'b1;
                        end else begin
                            n_rec.intf_count  = '0;
                            n_rec.beam_status = 1'b0;
                        end
                    end
                end
                n_rec.tx_on = 1'b0;
            end
        end
    end

    // record RAM: read on accept, write back from the update stage
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_rec <= r_mem[i_channel[ADDR_W-1:0]];
        end
        if (s1_wen) begin
            r_mem[r_s1_ch[ADDR_W-1:0]] <= n_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (s1_wen) begin
            r_vld[r_s1_ch[ADDR_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= DELAY_RESET;
            r_active <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DELAY:  r_delay  <= i_cfg_data;
                REG_ACTIVE: r_active <= i_cfg_data[ACT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                // RAM read misses the write landing on this same edge
                r_fwd      <= s1_wen && (r_s1_ch == i_channel);
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ch   <= i_channel;
            r_s1_beam <= !i_rx_level;
            r_rd_ok   <= r_vld[i_channel[ADDR_W-1:0]];
        end
        if (s1_wen) begin
            r_wr_rec <= n_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_ch <= r_s1_ch;
            if (!s1_in_range) begin
                r_out_tx  <= 1'b0;
                r_out_det <= 1'b0;
            end else if (s1_active) begin
                r_out_tx  <= n_rec.tx_on;
                r_out_det <= n_rec.beam_status;
            end else begin
                r_out_tx  <= cur.tx_on;
                r_out_det <= cur.beam_status;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_ch;
    assign o_tx_level    = r_out_tx;
    assign o_detected    = r_out_det;

endmodule

### test/ir_beam_door_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_beam_door_checker
// Monitors the tick and result channels of ir_beam_door_detector. Keeps its
// own per-channel sensor records and register copies, predicts one status per
// tick transfer and compares result transfers in order, field by field.
// ----------------------------------------------------------------------------
module ir_beam_door_checker
    import irbd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [CH_W-1:0]  i_channel,
    input  logic             i_rx_level,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [CH_W-1:0]  i_out_channel,
    input  logic             i_tx_level,
    input  logic             i_detected,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [CH_W-1:0] channel;
        logic            tx_level;
        logic            detected;
    } t_door_status;

    t_door_status           status_q[$];
    logic [CFG_W-1:0]       period_reg;
    logic [ACT_W-1:0]       active_reg;
    logic                   tx_on       [CHANNELS];
    logic [COUNT_WIDTH-1:0] off_cnt     [CHANNELS];
    logic [COUNT_WIDTH-1:0] on_cnt      [CHANNELS];
    logic [COUNT_WIDTH-1:0] intf_cnt    [CHANNELS];
    logic [1:0]             confirm_cnt [CHANNELS];
    logic [1:0]             miss_cnt    [CHANNELS];
    logic                   door_closed [CHANNELS];
    int                     fails = 0;

    // one tick of one active channel: off phase, on phase, sample at the end
    task automatic tick_sensor(input int ch, input bit beam);
        int period;
        period = int'(period_reg);
        if (!tx_on[ch]) begin
            on_cnt[ch] = '0;
            if (int'(off_cnt[ch]) < period) begin
                off_cnt[ch]++;
                if (beam) begin
                    // interference saturates at period-5, then it only
                    // knocks down the confirmations
                    if (int'(intf_cnt[ch]) < period - SETTLE_TICKS)
                        intf_cnt[ch]++;
                    else
                        confirm_cnt[ch] = '0;
                end
            end else begin
                tx_on[ch] = 1'b1;
            end
        end else begin
            off_cnt[ch] = '0;
            if (int'(on_cnt[ch]) < period) begin
                on_cnt[ch]++;
            end else begin
                if (beam && intf_cnt[ch] == '0) begin
                    if (int'(on_cnt[ch]) > SETTLE_TICKS) begin
                        if (confirm_cnt[ch] < QUALIFY_COUNT)
                            confirm_cnt[ch]++;
                        else
                            door_closed[ch] = 1'b1;
                    end
                    miss_cnt[ch] = '0;
                end else begin
                    confirm_cnt[ch] = '0;
                    if (int'(on_cnt[ch]) > SETTLE_TICKS) begin
                        if (miss_cnt[ch] < QUALIFY_COUNT) begin
                            miss_cnt[ch]++;
                        end else begin
                            intf_cnt[ch]    = '0;
                            door_closed[ch] = 1'b0;
                        end
                    end
                end
                tx_on[ch] = 1'b0;
            end
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_door_status got;
        t_door_status want;
        int           live;
        if (!i_rst_n) begin
            status_q.delete();
            period_reg = DELAY_RESET;
            active_reg = ACTIVE_RESET;
            for (int c = 0; c < CHANNELS; c++) begin
                tx_on[c]       = 1'b0;
                off_cnt[c]     = '0;
                on_cnt[c]      = '0;
                intf_cnt[c]    = '0;
                confirm_cnt[c] = '0;
                miss_cnt[c]    = '0;
                door_closed[c] = 1'b0;
            end
        end else begin
            if (i_cfg_we === 1'b1) begin
                if (i_cfg_index == REG_DELAY)
                    period_reg = i_cfg_data;
                else
                    active_reg = i_cfg_data[ACT_W-1:0];
            end

            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                got = '{i_out_channel, i_tx_level, i_detected};
                if (status_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result transfer with nothing pending: ch %0d tx %0b det %0b",
                                 $time, got.channel, got.tx_level, got.detected);
                end else begin
                    want = status_q.pop_front();
                    if (got.channel !== want.channel || got.tx_level !== want.tx_level ||
                        got.detected !== want.detected) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: status mismatch: expected ch %0d tx %0b det %0b, got ch %0d tx %0b det %0b",
                                     $time, want.channel, want.tx_level, want.detected,
                                     got.channel, got.tx_level, got.detected);
                    end
                end
            end

            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                // counts above the channel total act as all channels
                live = (active_reg > CHANNELS) ? CHANNELS : int'(active_reg);
                if (int'(i_channel) < live)
                    tick_sensor(int'(i_channel), i_rx_level == 1'b0);
                want.channel  = i_channel;
                want.tx_level = tx_on[i_channel];
                want.detected = door_closed[i_channel];
                status_q.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= status_q.size();
    end

endmodule

### test/tb_ir_beam_door_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ir_beam_door_detector
// Drives sensor ticks into ir_beam_door_detector: a short directed run over
// the period and channel-count corners, then random phases where each channel
// plays a scene (clear beam, blocked, ambient light, noise) under varying
// sender gaps and receiver stalls. The checker does all comparing.
// ----------------------------------------------------------------------------
module tb_ir_beam_door_detector;
    import irbd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;
    localparam int TAIL_CYCLES    = 10;

    typedef enum int {
        SCENE_CLEAR,
        SCENE_BLOCKED,
        SCENE_AMBIENT,
        SCENE_NOISY
    } t_scene;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    logic [CH_W-1:0]  i_channel   = '0;
    logic             i_rx_level  = 1'b1;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [CH_W-1:0]  o_out_channel;
    logic             o_tx_level;
    logic             o_detected;
    logic             i_cfg_we    = 1'b0;
    logic             i_cfg_index = REG_DELAY;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    int     fail_count;
    int     pending;
    int     tx_gap_pct   = 0;
    int     rx_stall_pct = 0;
    logic   hold_req     = 1'b0;
    logic   hold_ack     = 1'b0;
    int     hold_left    = 0;
    int     quiet        = 0;
    int     cur_delay    = DELAY_RESET;
    int     cur_active   = ACTIVE_RESET;
    // emitter phase per channel as the stimulus sees it, used to shape scenes
    logic   emitter_on  [CHANNELS];
    int     emitter_cnt [CHANNELS];
    t_scene scene       [CHANNELS];

    ir_beam_door_detector u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_channel     (i_channel),
        .i_rx_level    (i_rx_level),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_channel (o_out_channel),
        .o_tx_level    (o_tx_level),
        .o_detected    (o_detected),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    ir_beam_door_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_channel     (i_channel),
        .i_rx_level    (i_rx_level),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_channel (o_out_channel),
        .i_tx_level    (o_tx_level),
        .i_detected    (o_detected),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result side: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_ack    <= 1'b0;
            hold_left   <= 0;
        end else if (hold_req != hold_ack) begin
            hold_ack    <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("[ir_beam_door_detector] ERROR");
            $finish;
        end
    end

    function automatic int live_channels();
        return (cur_active > CHANNELS) ? CHANNELS : cur_active;
    endfunction

    // receiver pin level for the next tick of ch; 0 means beam seen
    function automatic logic scene_level(input int ch);
        int roll;
        if ($urandom_range(149) == 0) begin
            roll = $urandom_range(99);
            if (roll < 55)
                scene[ch] = SCENE_CLEAR;
            else if (roll < 80)
                scene[ch] = SCENE_BLOCKED;
            else if (roll < 88)
                scene[ch] = SCENE_AMBIENT;
            else
                scene[ch] = SCENE_NOISY;
        end
        case (scene[ch])
            SCENE_CLEAR: begin
                // beam only while the emitter is on, with a rare glitch
                if ($urandom_range(49) == 0)
                    return emitter_on[ch];
                return !emitter_on[ch];
            end
            SCENE_BLOCKED: return 1'b1;
            SCENE_AMBIENT: return 1'b0;
            default:       return logic'($urandom_range(1));
        endcase
    endfunction

    task automatic offer_tick(input int ch, input logic rx);
        while ($urandom_range(99) < tx_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_channel  <= CH_W'(ch);
        i_rx_level <= rx;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        // the emitter cycle runs regardless of what the receiver sees
        if (ch < live_channels()) begin
            if (emitter_cnt[ch] < cur_delay) begin
                emitter_cnt[ch]++;
            end else begin
                emitter_on[ch]  = !emitter_on[ch];
                emitter_cnt[ch] = 0;
            end
        end
    endtask

    task automatic program_sensor(input int delay, input int active);
        logic [CFG_W-1:0] word;
        word              = CFG_W'($urandom);
        word[ACT_W-1:0]   = ACT_W'(active);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_DELAY;
        i_cfg_data  <= CFG_W'(delay);
        @(posedge i_clk);
        i_cfg_index <= REG_ACTIVE;
        i_cfg_data  <= word;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_delay  = delay;
        cur_active = active;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int delay, input int active, input int gap_pct,
                             input int stall_pct, input int items, input bit squeeze);
        int done;
        int ch;
        bit held;
        bit paused;
        drain();
        program_sensor(delay, active);
        tx_gap_pct   = gap_pct;
        rx_stall_pct <= stall_pct;
        done   = 0;
        held   = 1'b0;
        paused = 1'b0;
        while (done < items) begin
            if ($urandom_range(9) == 0)
                ch = $urandom_range(CHANNELS - 1);
            else
                ch = $urandom_range(live_channels() - 1);
            if (squeeze && !held && done >= items / 3) begin
                hold_req <= ~hold_req;
                held = 1'b1;
            end
            if (squeeze && !paused && done >= 2 * items / 3) begin
                drain();
                paused = 1'b1;
            end
            offer_tick(ch, scene_level(ch));
            if (ch < live_channels())
                done++;
        end
    endtask

    initial begin : stimulus
        for (int c = 0; c < CHANNELS; c++) begin
            emitter_on[c]  = 1'b0;
            emitter_cnt[c] = 0;
            scene[c]       = SCENE_CLEAR;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: period 20, channel 0 only
        offer_tick(0, 1'b1);
        offer_tick(0, 1'b0);
        offer_tick(7, 1'b0);
        offer_tick(1, 1'b1);
        // zero period, no channel active
        drain();
        program_sensor(0, 0);
        offer_tick(0, 1'b0);
        offer_tick(4, 1'b1);
        // short period, channel count above the total
        drain();
        program_sensor(3, 15);
        repeat (12) offer_tick(7, scene_level(7));
        repeat (4) offer_tick(6, 1'b0);
        drain();
        program_sensor(0, 8);
        offer_tick(3, 1'b0);
        offer_tick(3, 1'b1);
        offer_tick(3, 1'b0);

        run_phase(6,    2,  0,  0,  250, 1'b0);
        run_phase(1023, 8,  49, 0,  100, 1'b0);
        run_phase(7,    3,  0,  49, 250, 1'b1);
        run_phase(5,    4,  30, 30, 150, 1'b0);
        run_phase(9,    1,  30, 30, 250, 1'b1);
        run_phase(10,   8,  49, 0,  200, 1'b0);
        run_phase(6,    15, 0,  49, 200, 1'b0);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ir_beam_door_detector] OK");
        else
            $display("[ir_beam_door_detector] ERROR");
        $finish;
    end

endmodule
